/* design/tqc_pkg.sv */
// ----------------------------------------------------------------------------
// tqc_pkg: shared types and constants for the tetrahedron quad cut test
// Fixed-point formats, pipeline stage indices and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tqc_pkg;

  localparam int COORD_BITS      = 21;
  localparam int BASIS_FRAC_BITS = 14;

  localparam int AXIS_W     = 16;
  localparam int AXES       = 3;
  localparam int LANES      = 4;
  localparam int ORIGIN_W   = 3 * COORD_BITS;
  localparam int AXIS_REG_W = 3 * AXIS_W;
  localparam int HALF_W     = 20;
  localparam int CFG_W      = (ORIGIN_W > AXIS_REG_W) ? ORIGIN_W : AXIS_REG_W;
  localparam int CFG_IDX_W  = 3;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = DIFF_W + AXIS_W;
  localparam int PROJ_W = PROD_W + 2;
  localparam int LIM_W  = HALF_W + BASIS_FRAC_BITS + 1;
  localparam int CMP_W  = (PROJ_W > LIM_W) ? PROJ_W : LIM_W;

  localparam int PROJ_N = 0;
  localparam int PROJ_U = 1;
  localparam int PROJ_V = 2;

  localparam int ST_DIFF  = 0;
  localparam int ST_PROD  = 1;
  localparam int ST_PROJ  = 2;
  localparam int ST_PAIR  = 3;
  localparam int ST_RANGE = 4;
  localparam int ST_OUT   = 5;
  localparam int NSTAGE   = 6;

  localparam logic [AXIS_REG_W-1:0] AXIS_U_RST = AXIS_REG_W'(48'd16384);
  localparam logic [AXIS_REG_W-1:0] AXIS_V_RST = AXIS_REG_W'(48'd1073741824);
  localparam logic [AXIS_REG_W-1:0] AXIS_N_RST = AXIS_REG_W'(48'd1073741824);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN = 3'd0,
    REG_AXIS_U = 3'd1,
    REG_AXIS_V = 3'd2,
    REG_AXIS_N = 3'd3,
    REG_HALF_W = 3'd4,
    REG_HALF_H = 3'd5
  } cfg_reg_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [AXIS_W-1:0]     axis_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [PROJ_W-1:0]     proj_t;
  typedef logic signed [CMP_W-1:0]      cmp_t;
  typedef logic        [HALF_W-1:0]     half_t;

  typedef struct packed {
    logic [NSTAGE-1:0] en;
  } pipe_ctl_t;

endpackage

`default_nettype wire

/* design/tqc_in_if.sv */
// ----------------------------------------------------------------------------
// tqc_in_if: tetrahedron input channel
// Valid/ready channel carrying the twelve vertex coordinates of one beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tqc_in_if;
  logic valid;
  logic ready;
  tqc_pkg::coord_t v0_x, v0_y, v0_z;
  tqc_pkg::coord_t v1_x, v1_y, v1_z;
  tqc_pkg::coord_t v2_x, v2_y, v2_z;
  tqc_pkg::coord_t v3_x, v3_y, v3_z;

  modport source (
    output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
    output v2_x, v2_y, v2_z, v3_x, v3_y, v3_z,
    input  ready
  );
  modport sink (
    input  valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
    input  v2_x, v2_y, v2_z, v3_x, v3_y, v3_z,
    output ready
  );
endinterface

`default_nettype wire

/* design/tqc_out_if.sv */
// ----------------------------------------------------------------------------
// tqc_out_if: cut flag output channel
// Valid/ready channel carrying one cut flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tqc_out_if;
  logic valid;
  logic ready;
  logic cut;

  modport source (output valid, cut, input ready);
  modport sink   (input valid, cut, output ready);
endinterface

`default_nettype wire

/* design/tqc_lane.sv */
// ----------------------------------------------------------------------------
// tqc_lane: per-vertex projection lane
// Offsets one vertex by the plane origin and projects it onto N, U and V
// over three registered stages: subtract, multiply, sum.
// ----------------------------------------------------------------------------
`default_nettype none

module tqc_lane (
  input  wire logic                clk_i,
  input  wire tqc_pkg::pipe_ctl_t  ctl_i,
  input  wire tqc_pkg::coord_t     vtx_i  [3],
  input  wire tqc_pkg::coord_t     org_i  [3],
  input  wire tqc_pkg::axis_t      axis_i [tqc_pkg::AXES][3],
  output      tqc_pkg::proj_t      proj_o [tqc_pkg::AXES]
);
  import tqc_pkg::*;

  diff_t diff_q [3];
  prod_t prod_q [AXES][3];
  proj_t proj_q [AXES];

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[ST_DIFF]) begin
      for (int k = 0; k < 3; k++) begin
        diff_q[k] <= diff_t'(vtx_i[k]) - diff_t'(org_i[k]);
      end
    end
    if (ctl_i.en[ST_PROD]) begin
      for (int a = 0; a < AXES; a++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[a][k] <= prod_t'(diff_q[k]) * prod_t'(axis_i[a][k]);
        end
      end
    end
    if (ctl_i.en[ST_PROJ]) begin
      for (int a = 0; a < AXES; a++) begin
        proj_q[a] <= proj_t'(prod_q[a][0]) + proj_t'(prod_q[a][1]) + proj_t'(prod_q[a][2]);
      end
    end
  end

  assign proj_o = proj_q;

endmodule

`default_nettype wire

/* design/tqc_merge.sv */
// ----------------------------------------------------------------------------
// tqc_merge: lane merge and bounds test
// Folds the four lanes' projections into side flags and U/V ranges over two
// registered levels, then tests straddle and quad overlap into the flag.
// ----------------------------------------------------------------------------
`default_nettype none

module tqc_merge (
  input  wire logic                clk_i,
  input  wire tqc_pkg::pipe_ctl_t  ctl_i,
  input  wire tqc_pkg::proj_t      proj_i [tqc_pkg::LANES][tqc_pkg::AXES],
  input  wire tqc_pkg::half_t      half_w_i,
  input  wire tqc_pkg::half_t      half_h_i,
  output      logic                cut_o
);
  import tqc_pkg::*;

  proj_t umn_q [2];
  proj_t umx_q [2];
  proj_t vmn_q [2];
  proj_t vmx_q [2];
  logic  fr_q  [2];
  logic  bk_q  [2];

  proj_t umin_q, umax_q, vmin_q, vmax_q;
  logic  front_q, back_q;
  logic  cut_q;

  cmp_t  lim_w, lim_h;

  function automatic proj_t pmin(proj_t a, proj_t b);
    return (b < a) ? b : a;
  endfunction

  function automatic proj_t pmax(proj_t a, proj_t b);
    return (b > a) ? b : a;
  endfunction

  function automatic logic overlaps(cmp_t a, cmp_t b, cmp_t c, cmp_t d);
    return ((c <= a) && (a <= d)) || ((a <= c) && (c <= b));
  endfunction

  assign lim_w = cmp_t'({half_w_i, {BASIS_FRAC_BITS{1'b0}}});
  assign lim_h = cmp_t'({half_h_i, {BASIS_FRAC_BITS{1'b0}}});

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[ST_PAIR]) begin
      for (int p = 0; p < 2; p++) begin
        umn_q[p] <= pmin(proj_i[2*p][PROJ_U], proj_i[2*p+1][PROJ_U]);
        umx_q[p] <= pmax(proj_i[2*p][PROJ_U], proj_i[2*p+1][PROJ_U]);
        vmn_q[p] <= pmin(proj_i[2*p][PROJ_V], proj_i[2*p+1][PROJ_V]);
        vmx_q[p] <= pmax(proj_i[2*p][PROJ_V], proj_i[2*p+1][PROJ_V]);
        fr_q[p]  <= !proj_i[2*p][PROJ_N][PROJ_W-1] || !proj_i[2*p+1][PROJ_N][PROJ_W-1];
        bk_q[p]  <= proj_i[2*p][PROJ_N][PROJ_W-1] || proj_i[2*p+1][PROJ_N][PROJ_W-1];
      end
    end
    if (ctl_i.en[ST_RANGE]) begin
      umin_q  <= pmin(umn_q[0], umn_q[1]);
      umax_q  <= pmax(umx_q[0], umx_q[1]);
      vmin_q  <= pmin(vmn_q[0], vmn_q[1]);
      vmax_q  <= pmax(vmx_q[0], vmx_q[1]);
      front_q <= fr_q[0] || fr_q[1];
      back_q  <= bk_q[0] || bk_q[1];
    end
    if (ctl_i.en[ST_OUT]) begin
      cut_q <= front_q && back_q
            && overlaps(cmp_t'(umin_q), cmp_t'(umax_q), -lim_w, lim_w)
            && overlaps(cmp_t'(vmin_q), cmp_t'(vmax_q), -lim_h, lim_h);
    end
  end

  assign cut_o = cut_q;

endmodule

`default_nettype wire

/* design/tet_quad_cut_test.sv */
// ----------------------------------------------------------------------------
// tet_quad_cut_test: finite-plane cut test, one tetrahedron per beat
// Each input beat on in_i carries the four vertices of one tetrahedron; each
// output beat on out_o carries one cut flag, in input order, one per input.
// The flag is set when the vertices straddle the plane (normal projection
// >= 0 on one side, < 0 on the other) and the U and V projection ranges
// overlap the quad's half extents.
// Plane origin, axes and half extents sit in registers written through the
// cfg_we_i/cfg_idx_i/cfg_data_i port; the user must write them only while no
// beat is in flight, which the block does not enforce. Throughput: one beat
// per cycle while out_o is not stalled, set by four vertex lanes (subtract,
// 9 multiplies, sum) feeding a two-level min/max merge and a compare stage.
// Stall: each stage advances when empty or when the next stage moves, so
// bubbles close up; with the receiver stalled the block still takes beats
// until all six stages are full, then drops in_i.ready.
// Reset: empties the pipeline and loads the register defaults (origin at
// zero, U = x, V = N = y, half extents zero). No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module tet_quad_cut_test (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [tqc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [tqc_pkg::CFG_W-1:0]       cfg_data_i,
  tqc_in_if.sink                               in_i,
  tqc_out_if.source                            out_o
);
  import tqc_pkg::*;

  logic [ORIGIN_W-1:0]   origin_q;
  logic [AXIS_REG_W-1:0] axu_q, axv_q, axn_q;
  half_t                 hw_q, hh_q;

  logic [NSTAGE-1:0] valid_q;
  logic [NSTAGE-1:0] en;
  pipe_ctl_t         ctl;

  coord_t org  [3];
  axis_t  ax   [AXES][3];
  coord_t vtx  [LANES][3];
  proj_t  proj [LANES][AXES];
  logic   cut;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= '0;
      axu_q    <= AXIS_U_RST;
      axv_q    <= AXIS_V_RST;
      axn_q    <= AXIS_N_RST;
      hw_q     <= '0;
      hh_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ORIGIN: origin_q <= cfg_data_i[ORIGIN_W-1:0];
        REG_AXIS_U: axu_q    <= cfg_data_i[AXIS_REG_W-1:0];
        REG_AXIS_V: axv_q    <= cfg_data_i[AXIS_REG_W-1:0];
        REG_AXIS_N: axn_q    <= cfg_data_i[AXIS_REG_W-1:0];
        REG_HALF_W: hw_q     <= cfg_data_i[HALF_W-1:0];
        REG_HALF_H: hh_q     <= cfg_data_i[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      org[k]        = coord_t'(origin_q[k*COORD_BITS +: COORD_BITS]);
      ax[PROJ_N][k] = axis_t'(axn_q[k*AXIS_W +: AXIS_W]);
      ax[PROJ_U][k] = axis_t'(axu_q[k*AXIS_W +: AXIS_W]);
      ax[PROJ_V][k] = axis_t'(axv_q[k*AXIS_W +: AXIS_W]);
    end
  end

  assign vtx[0][0] = in_i.v0_x;
  assign vtx[0][1] = in_i.v0_y;
  assign vtx[0][2] = in_i.v0_z;
  assign vtx[1][0] = in_i.v1_x;
  assign vtx[1][1] = in_i.v1_y;
  assign vtx[1][2] = in_i.v1_z;
  assign vtx[2][0] = in_i.v2_x;
  assign vtx[2][1] = in_i.v2_y;
  assign vtx[2][2] = in_i.v2_z;
  assign vtx[3][0] = in_i.v3_x;
  assign vtx[3][1] = in_i.v3_y;
  assign vtx[3][2] = in_i.v3_z;

  // advance a stage when it is empty or its successor advances
  always_comb begin
    en[NSTAGE-1] = !valid_q[NSTAGE-1] || out_o.ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign ctl.en = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    tqc_lane u_lane (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .vtx_i  (vtx[l]),
      .org_i  (org),
      .axis_i (ax),
      .proj_o (proj[l])
    );
  end

  tqc_merge u_merge (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .proj_i   (proj),
    .half_w_i (hw_q),
    .half_h_i (hh_q),
    .cut_o    (cut)
  );

  assign in_i.ready  = en[0];
  assign out_o.valid = valid_q[NSTAGE-1];
  assign out_o.cut   = cut;

  a_full_when_blocked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (&valid_q))
    else $error("input blocked with a bubble in the pipeline");

  a_beat_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> valid_q[0])
    else $error("accepted beat missing from first stage");

  a_out_refill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready) |=> (valid_q[NSTAGE-1] == $past(valid_q[NSTAGE-2])))
    else $error("output stage not refilled from its predecessor");

endmodule

`default_nettype wire

/* verif/tb_tet_quad_cut_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tet_quad_cut_test: self-checking bench for the tetrahedron quad cut test
// Streams tetrahedra through the block under several plane settings. Each
// setting is loaded while the pipeline is empty. A scoreboard works out the
// cut flag of every accepted tetrahedron from its own copy of the
// registers. It compares the flags in order, while both channels idle and
// stall at random in most phases.
// ----------------------------------------------------------------------------

package tqc_sb_pkg;
  import tqc_pkg::*;

  typedef coord_t tet_t [LANES][AXES];

  class cut_scoreboard;
    logic [ORIGIN_W-1:0]   origin_r;
    logic [AXIS_REG_W-1:0] axis_u_r;
    logic [AXIS_REG_W-1:0] axis_v_r;
    logic [AXIS_REG_W-1:0] axis_n_r;
    half_t                 half_w_r;
    half_t                 half_h_r;
    bit                    cut_flags_q [$];
    int unsigned           errors;

    function new();
      origin_r = '0;
      axis_u_r = AXIS_U_RST;
      axis_v_r = AXIS_V_RST;
      axis_n_r = AXIS_N_RST;
      half_w_r = '0;
      half_h_r = '0;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_ORIGIN: origin_r = data[ORIGIN_W-1:0];
        REG_AXIS_U: axis_u_r = data[AXIS_REG_W-1:0];
        REG_AXIS_V: axis_v_r = data[AXIS_REG_W-1:0];
        REG_AXIS_N: axis_n_r = data[AXIS_REG_W-1:0];
        REG_HALF_W: half_w_r = data[HALF_W-1:0];
        REG_HALF_H: half_h_r = data[HALF_W-1:0];
        default: ;
      endcase
    endfunction

    function longint origin_at(int k);
      return $signed(origin_r[k*COORD_BITS +: COORD_BITS]);
    endfunction

    function longint project(longint d [AXES], logic [AXIS_REG_W-1:0] axis);
      longint acc;
      acc = 0;
      for (int k = 0; k < AXES; k++) begin
        acc += d[k] * longint'($signed(axis[k*AXIS_W +: AXIS_W]));
      end
      return acc;
    endfunction

    function bit spans(longint lo, longint hi, longint lim);
      return (-lim <= lo && lo <= lim) || (lo <= -lim && -lim <= hi);
    endfunction

    function bit cut_of(tet_t t);
      longint d [AXES];
      longint pu, pv, umin, umax, vmin, vmax, hw, hh;
      bit     front, back;
      front = 1'b0;
      back  = 1'b0;
      umin  = 0;
      umax  = 0;
      vmin  = 0;
      vmax  = 0;
      for (int i = 0; i < LANES; i++) begin
        for (int k = 0; k < AXES; k++) begin
          d[k] = longint'(t[i][k]) - origin_at(k);
        end
        if (project(d, axis_n_r) >= 0) front = 1'b1;
        else back = 1'b1;
        pu = project(d, axis_u_r);
        pv = project(d, axis_v_r);
        if (i == 0 || pu < umin) umin = pu;
        if (i == 0 || pu > umax) umax = pu;
        if (i == 0 || pv < vmin) vmin = pv;
        if (i == 0 || pv > vmax) vmax = pv;
      end
      hw = longint'(half_w_r) << BASIS_FRAC_BITS;
      hh = longint'(half_h_r) << BASIS_FRAC_BITS;
      return front && back && spans(umin, umax, hw) && spans(vmin, vmax, hh);
    endfunction

    function void note_tet(tet_t t);
      cut_flags_q.push_back(cut_of(t));
    endfunction

    function void check_flag(logic cut);
      bit want;
      if (cut_flags_q.size() == 0) begin
        $display("%0t: cut flag %b with no tetrahedron outstanding", $time, cut);
        errors++;
      end else begin
        want = cut_flags_q.pop_front();
        if (cut !== want) begin
          $display("%0t: cut flag mismatch, expected %b, got %b", $time, want, cut);
          errors++;
        end
      end
    endfunction

    function int pending();
      return cut_flags_q.size();
    endfunction
  endclass
endpackage

module tb_tet_quad_cut_test;
  import tqc_pkg::*;
  import tqc_sb_pkg::*;

  localparam int COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;
  localparam int COORD_MIN   = -(1 << (COORD_BITS - 1));
  localparam int ONE         = 1 << BASIS_FRAC_BITS;
  localparam int LATENCY     = 6;
  localparam int NPHASE      = 8;
  localparam int PHASE_ITEMS = 160;
  localparam int HOLD_CYCLES = 40;
  localparam int STALL_LIMIT = 1000;
  localparam int DIRECTED_N  = 14;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int DIRECTED [DIRECTED_N][LANES*AXES] = '{
    '{0, 0, 0,   0, 0, 0,   0, 0, 0,   0, 0, 0},
    '{0, 0, 0,  -5, -3, 7,  5, -1, 0,  2, -2, 9},
    '{0, -1, 0, -5, -3, 7,  5, -1, 0,  2, -2, 9},
    '{1, 4, 0,   5, -3, 7,  9, -1, 0,  2, -2, 9},
    '{0, 4, 0,  -5, -3, 7, -9, -1, 0, -2, -2, 9},
    '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
      COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX},
    '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
      COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN},
    '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
      COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN},
    '{COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
      COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX},
    '{3, 5, 1,  -4, 2, 0,   7, -6, 3,  1, 9, -8},
    '{3, 5, 1,   4, 2, 0,   7, -6, 3,  1, 9, -8},
    '{-1, 0, 0,  1, 0, 0,   0, -1, 0,  0, 0, 1},
    '{0, 0, 0,   0, 0, 0,   0, 0, 0,   0, -1, 0},
    '{COORD_MAX, 0, 0, COORD_MIN, -1, 0, 0, COORD_MAX, COORD_MIN, 0, COORD_MIN, COORD_MAX}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  tqc_in_if  in_if ();
  tqc_out_if out_if ();

  tet_quad_cut_test u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  cut_scoreboard sb;
  int            gap_pct;
  int            stall_pct;
  bit            calm;
  bit            hold_req;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic coord_t clamp_coord(longint x);
    if (x > COORD_MAX) return coord_t'(COORD_MAX);
    if (x < COORD_MIN) return coord_t'(COORD_MIN);
    return coord_t'(x);
  endfunction

  function automatic longint signed_rand(int span);
    return longint'($urandom_range(0, 2 << span)) - (longint'(1) << span);
  endfunction

  function automatic tet_t random_tet();
    tet_t   t;
    longint hub;
    int     span_c, span_v;
    if ($urandom_range(0, 99) < 15) begin
      for (int i = 0; i < LANES; i++) begin
        for (int k = 0; k < AXES; k++) t[i][k] = coord_t'($urandom);
      end
    end else begin
      span_c = $urandom_range(0, 19);
      span_v = $urandom_range(0, 14);
      for (int k = 0; k < AXES; k++) begin
        hub = sb.origin_at(k) + signed_rand(span_c);
        for (int i = 0; i < LANES; i++) t[i][k] = clamp_coord(hub + signed_rand(span_v));
      end
    end
    return t;
  endfunction

  function automatic logic [AXIS_REG_W-1:0] pack_axis(int x, int y, int z);
    return {AXIS_W'(z), AXIS_W'(y), AXIS_W'(x)};
  endfunction

  function automatic logic [ORIGIN_W-1:0] pack_origin(int x, int y, int z);
    return {COORD_BITS'(z), COORD_BITS'(y), COORD_BITS'(x)};
  endfunction

  // fill the bits above the register width now and then; they must be dropped
  function automatic logic [CFG_W-1:0] with_junk(logic [CFG_W-1:0] value, int width);
    logic [CFG_W-1:0] junk;
    logic [CFG_W-1:0] mask;
    junk = CFG_W'({$urandom, $urandom});
    mask = {CFG_W{1'b1}} << width;
    return ($urandom_range(0, 1) != 0) ? (value | (junk & mask)) : value;
  endfunction

  task automatic put_fields(input tet_t t);
    in_if.v0_x <= t[0][0];
    in_if.v0_y <= t[0][1];
    in_if.v0_z <= t[0][2];
    in_if.v1_x <= t[1][0];
    in_if.v1_y <= t[1][1];
    in_if.v1_z <= t[1][2];
    in_if.v2_x <= t[2][0];
    in_if.v2_y <= t[2][1];
    in_if.v2_z <= t[2][2];
    in_if.v3_x <= t[3][0];
    in_if.v3_y <= t[3][1];
    in_if.v3_z <= t[3][2];
  endtask

  task automatic send_tet(input tet_t t);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    put_fields(t);
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_tet(t);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic load_setting(input int p);
    logic [ORIGIN_W-1:0]   org;
    logic [AXIS_REG_W-1:0] au, av, an;
    half_t                 hw, hh;
    org = pack_origin($urandom, $urandom, $urandom);
    au  = AXIS_REG_W'({$urandom, $urandom});
    av  = AXIS_REG_W'({$urandom, $urandom});
    an  = AXIS_REG_W'({$urandom, $urandom});
    hw  = half_t'($urandom);
    hh  = half_t'($urandom);
    case (p)
      0: begin
        org = '0;
        au  = pack_axis(ONE, 0, 0);
        av  = pack_axis(0, ONE, 0);
        an  = pack_axis(0, 0, ONE);
        hw  = half_t'(64 << 10);
        hh  = half_t'(32 << 10);
      end
      1: begin
        org = pack_origin(COORD_MAX, COORD_MAX, COORD_MAX);
        au  = {3{16'h8000}};
        av  = {3{16'h8000}};
        an  = {3{16'h8000}};
        hw  = '1;
        hh  = '1;
      end
      2: begin
        org = pack_origin(COORD_MIN, COORD_MIN, COORD_MIN);
        au  = {3{16'h7fff}};
        av  = {3{16'h7fff}};
        an  = {3{16'h7fff}};
        hw  = '0;
        hh  = '0;
      end
      4: begin
        av = '0;
        an = '0;
      end
      5: begin
        hw = half_t'($urandom_range(0, 4095));
        hh = half_t'($urandom_range(0, 4095));
      end
      6: begin
        au = pack_axis(0, ONE, 0);
        av = pack_axis(0, 0, -ONE);
        an = pack_axis(ONE, 0, 0);
        hw = half_t'($urandom_range(0, 1 << 16));
        hh = half_t'($urandom_range(0, 1 << 16));
      end
      7: begin
        hw = half_t'($urandom_range(0, 1 << 18));
        hh = half_t'($urandom_range(0, 1 << 18));
      end
      default: ;
    endcase
    write_reg(REG_ORIGIN, with_junk(CFG_W'(org), ORIGIN_W));
    write_reg(REG_AXIS_U, with_junk(CFG_W'(au), AXIS_REG_W));
    write_reg(REG_AXIS_V, with_junk(CFG_W'(av), AXIS_REG_W));
    write_reg(REG_AXIS_N, with_junk(CFG_W'(an), AXIS_REG_W));
    write_reg(REG_HALF_W, with_junk(CFG_W'(hw), HALF_W));
    write_reg(REG_HALF_H, with_junk(CFG_W'(hh), HALF_W));
    if (p == 4) begin
      write_reg(REG_SPARE_LO, CFG_W'({$urandom, $urandom}));
      write_reg(REG_SPARE_HI, CFG_W'({$urandom, $urandom}));
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_flag(out_if.cut);
  end

  initial begin
    int unsigned idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_run = 0;
      else idle_run++;
    end
    $display("tet_quad_cut_test test failed");
    $finish;
  end

  initial begin
    tet_t t;
    sb        = new();
    gap_pct   = 30;
    stall_pct = 30;
    calm      = 1'b0;
    hold_req  = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      for (int k = 0; k < AXES; k++) t[i][k] = '0;
    end
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_ORIGIN;
    cfg_data_i  <= '0;
    in_if.valid <= 1'b0;
    put_fields(t);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int n = 0; n < DIRECTED_N; n++) begin
      for (int i = 0; i < LANES; i++) begin
        for (int k = 0; k < AXES; k++) t[i][k] = coord_t'(DIRECTED[n][i*AXES+k]);
      end
      send_tet(t);
    end
    in_if.valid <= 1'b0;

    for (int p = 0; p < NPHASE; p++) begin
      wait_drained();
      @(posedge clk_i);
      load_setting(p);
      calm      = (p == NPHASE - 1);
      gap_pct   = (p == 0) ? 0 : $urandom_range(10, 40);
      stall_pct = (p == 0) ? 0 : $urandom_range(10, 40);
      if (p == 1) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_tet(random_tet());
      in_if.valid <= 1'b0;
    end

    wait_drained();
    repeat (2 * LATENCY) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tet_quad_cut_test test passed");
    end else begin
      $display("tet_quad_cut_test test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/tqc_pkg.sv
design/tqc_in_if.sv
design/tqc_out_if.sv
design/tqc_lane.sv
design/tqc_merge.sv
design/tet_quad_cut_test.sv
verif/tb_tet_quad_cut_test.sv
